/* hdl/calendar_month_navigator_macros.svh */
// Assertion macros used by the calendar month navigator checker.
`ifndef CALENDAR_MONTH_NAVIGATOR_MACROS_SVH
`define CALENDAR_MONTH_NAVIGATOR_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define CMN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define CMN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/cmn_pkg.sv */
// Shared types, constants and calendar functions for the month navigator.
`default_nettype none

package cmn_pkg;

    localparam logic [13:0] YEAR_MIN   = 14'd1;
    localparam logic [13:0] YEAR_MAX   = 14'd9999;
    localparam logic [3:0]  MONTH_LAST = 4'd11;
    localparam logic [6:0]  PAIR_LAST  = 7'd99;
    localparam logic [6:0]  CENT_RESET = 7'd20;
    localparam logic [6:0]  YY_RESET   = 7'd26;
    localparam logic [3:0]  MONTH_RESET = 4'd0;
    localparam logic [4:0]  DAY_RESET  = 5'd1;

    // floor(y / 100) = (y * 5243) >> 19, exact for any 14-bit y
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef enum logic [1:0] {
        OP_PREV   = 2'd0,
        OP_NEXT   = 2'd1,
        OP_TODAY  = 2'd2,
        OP_SELECT = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [4:0] day;
        logic       now_ok;
        logic [6:0] now_cent;
        logic [6:0] now_yy;
        logic [3:0] now_month;
        logic [4:0] now_day;
    } t_cmd;

    typedef struct packed {
        logic [6:0] cent;
        logic [6:0] yy;
        logic [3:0] month;
        logic [4:0] sel;
        logic       acc;
    } t_view;

    function automatic logic is_leap(input logic [6:0] cent, input logic [6:0] yy);
        return ((yy[1:0] == 2'd0) && (yy != 7'd0)) || ((yy == 7'd0) && (cent[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1:    len = leap ? 5'd29 : 5'd28;
            4'd3:    len = 5'd30;
            4'd5:    len = 5'd30;
            4'd8:    len = 5'd30;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(13 * (m + 1) / 5), January and February counted as months 13 and 14
    function automatic logic [5:0] month_term(input logic [3:0] month);
        logic [5:0] t;
        case (month)
            4'd0:    t = 6'd36;
            4'd1:    t = 6'd39;
            4'd2:    t = 6'd10;
            4'd3:    t = 6'd13;
            4'd4:    t = 6'd15;
            4'd5:    t = 6'd18;
            4'd6:    t = 6'd20;
            4'd7:    t = 6'd23;
            4'd8:    t = 6'd26;
            4'd9:    t = 6'd28;
            4'd10:   t = 6'd31;
            default: t = 6'd33;
        endcase
        return t;
    endfunction

    // base-8 digit folding, 8 = 1 mod 7
    function automatic logic [2:0] mod7(input logic [9:0] x);
        logic [7:0] a;
        logic [5:0] b;
        logic [3:0] c;
        a = {1'b0, x[9:3]} + {5'd0, x[2:0]};
        b = {1'b0, a[7:3]} + {3'd0, a[2:0]};
        c = {1'b0, b[5:3]} + {1'b0, b[2:0]};
        if (c >= 4'd7) begin
            c = c - 4'd7;
        end
        return c[2:0];
    endfunction

endpackage

`default_nettype wire

/* hdl/cmn_front.sv */
// Front end: registers requests and classifies them, checking the supplied date.
`default_nettype none

module cmn_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [1:0]    i_mode,
    input  wire logic [4:0]    i_day,
    input  wire logic          i_now_valid,
    input  wire logic [13:0]   i_now_year,
    input  wire logic [3:0]    i_now_month,
    input  wire logic [4:0]    i_now_day,
    input  wire logic          i_full,
    output logic               o_push,
    output cmn_pkg::t_cmd      o_cmd
);

    logic             r_valid;
    cmn_pkg::t_op     r_op;
    logic [4:0]       r_day;
    logic             r_now_valid;
    logic [13:0]      r_now_year;
    logic [3:0]       r_now_month;
    logic [4:0]       r_now_day;
    logic [7:0]       r_cent;

    logic [26:0]      prod;
    logic [13:0]      hundreds;
    logic [13:0]      rem;
    logic [3:0]       mon_idx;
    logic             leap;
    logic             now_ok;

    assign o_stall = r_valid && i_full;
    assign prod    = {13'd0, i_now_year} * {14'd0, cmn_pkg::DIV100_MUL};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_op        <= cmn_pkg::t_op'(i_mode);
            r_day       <= i_day;
            r_now_valid <= i_now_valid;
            r_now_year  <= i_now_year;
            r_now_month <= i_now_month;
            r_now_day   <= i_now_day;
            r_cent      <= prod[cmn_pkg::DIV100_SHIFT +: 8];
        end
    end

    always_comb begin
        hundreds = ({6'd0, r_cent} << 6) + ({6'd0, r_cent} << 5) + ({6'd0, r_cent} << 2);
        rem      = r_now_year - hundreds;
        mon_idx  = r_now_month - 4'd1;
        leap     = cmn_pkg::is_leap(r_cent[6:0], rem[6:0]);
        now_ok   = r_now_valid
                && (r_now_year >= cmn_pkg::YEAR_MIN) && (r_now_year <= cmn_pkg::YEAR_MAX)
                && (r_now_month >= 4'd1) && (r_now_month <= 4'd12)
                && (r_now_day >= 5'd1) && (r_now_day <= cmn_pkg::month_len(mon_idx, leap));

        o_cmd.op        = r_op;
        o_cmd.day       = r_day;
        o_cmd.now_ok    = now_ok;
        o_cmd.now_cent  = r_cent[6:0];
        o_cmd.now_yy    = rem[6:0];
        o_cmd.now_month = mon_idx;
        o_cmd.now_day   = r_now_day;
    end

    assign o_push = r_valid && !i_full;

endmodule

`default_nettype wire

/* hdl/cmn_queue.sv */
// Short request queue between the front end and the executing back end.
`default_nettype none

module cmn_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire cmn_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output cmn_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);

    localparam logic [cmn_pkg::QCNT_W-1:0] FULL_COUNT = cmn_pkg::QCNT_W'(cmn_pkg::QUEUE_DEPTH);

    cmn_pkg::t_cmd                 r_mem [cmn_pkg::QUEUE_DEPTH];
    logic [cmn_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [cmn_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [cmn_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

/* hdl/cmn_exec.sv */
// Back end: holds the view and known date and applies each request.
`default_nettype none

module cmn_exec (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire cmn_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    output cmn_pkg::t_view     o_view,
    input  wire logic          i_take
);

    logic [6:0]      r_cent,  n_cent;
    logic [6:0]      r_yy,    n_yy;
    logic [3:0]      r_month, n_month;
    logic [4:0]      r_sel,   n_sel;
    logic [6:0]      r_k_cent,  n_k_cent;
    logic [6:0]      r_k_yy,    n_k_yy;
    logic [3:0]      r_k_month, n_k_month;
    logic [4:0]      r_k_day,   n_k_day;
    logic            n_acc;
    logic            r_valid;
    cmn_pkg::t_view  r_view;
    logic            ready;

    assign ready   = !r_valid || i_take;
    assign o_pop   = i_q_valid && ready;
    assign o_valid = r_valid;
    assign o_view  = r_view;

    always_comb begin
        n_cent    = r_cent;
        n_yy      = r_yy;
        n_month   = r_month;
        n_sel     = r_sel;
        n_k_cent  = r_k_cent;
        n_k_yy    = r_k_yy;
        n_k_month = r_k_month;
        n_k_day   = r_k_day;
        n_acc     = 1'b1;
        unique case (i_cmd.op)
            cmn_pkg::OP_PREV: begin
                if (r_month == 4'd0) begin
                    if (!((r_cent == 7'd0) && (r_yy == 7'd1))) begin
                        n_month = cmn_pkg::MONTH_LAST;
                        if (r_yy == 7'd0) begin
                            n_cent = r_cent - 7'd1;
                            n_yy   = cmn_pkg::PAIR_LAST;
                        end else begin
                            n_yy   = r_yy - 7'd1;
                        end
                    end
                end else begin
                    n_month = r_month - 4'd1;
                end
                n_sel = 5'd0;
            end
            cmn_pkg::OP_NEXT: begin
                if (r_month >= cmn_pkg::MONTH_LAST) begin
                    if (!((r_cent == cmn_pkg::PAIR_LAST) && (r_yy == cmn_pkg::PAIR_LAST))) begin
                        n_month = 4'd0;
                        if (r_yy == cmn_pkg::PAIR_LAST) begin
                            n_cent = r_cent + 7'd1;
                            n_yy   = 7'd0;
                        end else begin
                            n_yy   = r_yy + 7'd1;
                        end
                    end
                end else begin
                    n_month = r_month + 4'd1;
                end
                n_sel = 5'd0;
            end
            cmn_pkg::OP_TODAY: begin
                if (i_cmd.now_ok) begin
                    n_k_cent  = i_cmd.now_cent;
                    n_k_yy    = i_cmd.now_yy;
                    n_k_month = i_cmd.now_month;
                    n_k_day   = i_cmd.now_day;
                end
                n_cent  = n_k_cent;
                n_yy    = n_k_yy;
                n_month = n_k_month;
                n_sel   = n_k_day;
            end
            cmn_pkg::OP_SELECT: begin
                if ((i_cmd.day >= 5'd1) && (i_cmd.day <=
                        cmn_pkg::month_len(r_month, cmn_pkg::is_leap(r_cent, r_yy)))) begin
                    n_sel = i_cmd.day;
                end else begin
                    n_acc = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cent    <= cmn_pkg::CENT_RESET;
            r_yy      <= cmn_pkg::YY_RESET;
            r_month   <= cmn_pkg::MONTH_RESET;
            r_sel     <= 5'd0;
            r_k_cent  <= cmn_pkg::CENT_RESET;
            r_k_yy    <= cmn_pkg::YY_RESET;
            r_k_month <= cmn_pkg::MONTH_RESET;
            r_k_day   <= cmn_pkg::DAY_RESET;
            r_valid   <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cent    <= n_cent;
                r_yy      <= n_yy;
                r_month   <= n_month;
                r_sel     <= n_sel;
                r_k_cent  <= n_k_cent;
                r_k_yy    <= n_k_yy;
                r_k_month <= n_k_month;
                r_k_day   <= n_k_day;
            end
            if (ready) begin
                r_valid <= o_pop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_view.cent  <= n_cent;
            r_view.yy    <= n_yy;
            r_view.month <= n_month;
            r_view.sel   <= n_sel;
            r_view.acc   <= n_acc;
        end
    end

endmodule

`default_nettype wire

/* hdl/cmn_format.sv */
// Result stage: month length, weekday of the 1st and the output register.
`default_nettype none

module cmn_format (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire cmn_pkg::t_view i_view,
    output logic                o_take,
    output logic                o_valid,
    input  wire logic           i_stall,
    output logic [13:0]         o_view_year_out,
    output logic [3:0]          o_view_month_out,
    output logic [4:0]          o_picked_day,
    output logic [4:0]          o_month_length,
    output logic [2:0]          o_first_weekday,
    output logic                o_accepted
);

    logic        r_valid;
    logic [13:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_sel;
    logic [4:0]  r_len;
    logic [2:0]  r_wday;
    logic        r_acc;

    logic        out_ready;
    logic [13:0] year;
    logic [6:0]  z_cent;
    logic [6:0]  z_yy;
    logic [9:0]  z_sum;

    assign out_ready = !r_valid || !i_stall;
    assign o_take    = i_valid && out_ready;

    always_comb begin
        year = ({7'd0, i_view.cent} << 6) + ({7'd0, i_view.cent} << 5)
             + ({7'd0, i_view.cent} << 2) + {7'd0, i_view.yy};
        z_cent = i_view.cent;
        z_yy   = i_view.yy;
        if (i_view.month < 4'd2) begin
            if (i_view.yy == 7'd0) begin
                z_cent = i_view.cent - 7'd1;
                z_yy   = cmn_pkg::PAIR_LAST;
            end else begin
                z_yy   = i_view.yy - 7'd1;
            end
        end
        // the +1 of the day and the +6 that moves Saturday-first to Sunday-first cancel mod 7
        z_sum = {4'd0, cmn_pkg::month_term(i_view.month)}
              + {3'd0, z_yy} + {5'd0, z_yy[6:2]}
              + {5'd0, z_cent[6:2]}
              + ({3'd0, z_cent} << 2) + {3'd0, z_cent};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_year  <= year;
            r_month <= i_view.month;
            r_sel   <= i_view.sel;
            r_len   <= cmn_pkg::month_len(i_view.month, cmn_pkg::is_leap(i_view.cent, i_view.yy));
            r_wday  <= cmn_pkg::mod7(z_sum);
            r_acc   <= i_view.acc;
        end
    end

    assign o_valid          = r_valid;
    assign o_view_year_out  = r_year;
    assign o_view_month_out = r_month;
    assign o_picked_day     = r_sel;
    assign o_month_length   = r_len;
    assign o_first_weekday  = r_wday;
    assign o_accepted       = r_acc;

endmodule

`default_nettype wire

/* hdl/calendar_month_navigator.sv */
// Calendar month navigator: keeps the viewed month, selection and known date.
//
// Request channel: i_valid / o_stall with i_mode, i_day and the current date
// i_now_*. A request is taken on a rising edge with i_valid high and o_stall low.
// Result channel: o_valid / i_stall, one result per request, in request order.
// A taken request passes the front register, the queue, the state update stage
// and the result register before its result shows on o_valid.
// Throughput: one request per cycle while o_stall is low; every command is a
// single-step state update and the calendar arithmetic uses constant divisors only.
// A two-entry queue parts the front from the back end; when the receiver
// stalls, the result register holds, the back end fills, then the queue, and
// o_stall rises once the queue is full and the front register holds a request.
// Reset (i_rst_n low, synchronous) empties all stages and sets the view to
// January 2026 with no day selected, and the known date to 1 January 2026.
`default_nettype none

module calendar_month_navigator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [4:0]  i_day,
    input  wire logic        i_now_valid,
    input  wire logic [13:0] i_now_year,
    input  wire logic [3:0]  i_now_month,
    input  wire logic [4:0]  i_now_day,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [13:0]      o_view_year_out,
    output logic [3:0]       o_view_month_out,
    output logic [4:0]       o_picked_day,
    output logic [4:0]       o_month_length,
    output logic [2:0]       o_first_weekday,
    output logic             o_accepted
);

    logic            push;
    logic            full;
    cmn_pkg::t_cmd   push_cmd;
    logic            q_valid;
    cmn_pkg::t_cmd   q_cmd;
    logic            pop;
    logic            view_valid;
    cmn_pkg::t_view  view;
    logic            take;

    cmn_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_mode      (i_mode),
        .i_day       (i_day),
        .i_now_valid (i_now_valid),
        .i_now_year  (i_now_year),
        .i_now_month (i_now_month),
        .i_now_day   (i_now_day),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    cmn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    cmn_exec u_exec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_valid   (view_valid),
        .o_view    (view),
        .i_take    (take)
    );

    cmn_format u_format (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (view_valid),
        .i_view           (view),
        .o_take           (take),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_view_year_out  (o_view_year_out),
        .o_view_month_out (o_view_month_out),
        .o_picked_day     (o_picked_day),
        .o_month_length   (o_month_length),
        .o_first_weekday  (o_first_weekday),
        .o_accepted       (o_accepted)
    );

endmodule

`default_nettype wire

/* hdl/cmn_checker.sv */
// Port-level checks for the calendar month navigator, bound to the top level.
`default_nettype none

`include "calendar_month_navigator_macros.svh"

module cmn_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [13:0] o_view_year_out,
    input wire logic [3:0]  o_view_month_out,
    input wire logic [4:0]  o_picked_day,
    input wire logic [4:0]  o_month_length,
    input wire logic [2:0]  o_first_weekday,
    input wire logic        o_accepted
);

    `CMN_ASSERT_NEXT(a_result_hold, o_valid && i_stall,
        o_valid && $stable(o_view_year_out) && $stable(o_view_month_out)
        && $stable(o_picked_day) && $stable(o_accepted), "stalled result changed")

    `CMN_ASSERT_NOW(a_month_range, o_valid,
        (o_view_month_out <= 4'd11) && (o_month_length >= 5'd28)
        && (o_month_length <= 5'd31) && (o_first_weekday <= 3'd6), "month fields out of range")

    `CMN_ASSERT_NOW(a_year_range, o_valid,
        (o_view_year_out >= 14'd1) && (o_view_year_out <= 14'd9999), "viewed year out of range")

    `CMN_ASSERT_NOW(a_pick_in_month, o_valid,
        o_picked_day <= o_month_length, "selected day beyond month length")

endmodule

bind calendar_month_navigator cmn_checker u_cmn_checker (.*);

`default_nettype wire

/* tb/calendar_month_navigator_tb.sv */
// Self-checking testbench for the calendar month navigator: directed and random requests.
module calendar_month_navigator_tb;

    localparam int RESET_CYCLES    = 7;
    localparam int RANDOM_REQUESTS = 2000;
    localparam int HOLD_CYCLES     = 80;
    localparam int SETTLE_CYCLES   = 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PRINT_CAP       = 60;

    typedef struct {
        cmn_pkg::t_op op;
        logic [4:0]   day;
        logic         now_valid;
        logic [13:0]  now_year;
        logic [3:0]   now_month;
        logic [4:0]   now_day;
    } t_nav_cmd;

    typedef struct {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  pick;
        logic [4:0]  len;
        logic [2:0]  dow;
        logic        acc;
    } t_month_view;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        i_stall     = 1'b0;
    logic [1:0]  i_mode      = '0;
    logic [4:0]  i_day       = '0;
    logic        i_now_valid = 1'b0;
    logic [13:0] i_now_year  = '0;
    logic [3:0]  i_now_month = '0;
    logic [4:0]  i_now_day   = '0;
    logic        o_stall;
    logic        o_valid;
    logic [13:0] o_view_year_out;
    logic [3:0]  o_view_month_out;
    logic [4:0]  o_picked_day;
    logic [4:0]  o_month_length;
    logic [2:0]  o_first_weekday;
    logic        o_accepted;

    calendar_month_navigator u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_day            (i_day),
        .i_now_valid      (i_now_valid),
        .i_now_year       (i_now_year),
        .i_now_month      (i_now_month),
        .i_now_day        (i_now_day),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_view_year_out  (o_view_year_out),
        .o_view_month_out (o_view_month_out),
        .o_picked_day     (o_picked_day),
        .o_month_length   (o_month_length),
        .o_first_weekday  (o_first_weekday),
        .o_accepted       (o_accepted)
    );

    // calendar state as the block should hold it
    logic [13:0] cal_year    = 14'd2026;
    logic [3:0]  cal_month   = 4'd0;
    logic [4:0]  cal_pick    = 5'd0;
    logic [13:0] kept_year   = 14'd2026;
    logic [3:0]  today_month = 4'd0;
    logic [4:0]  today_day   = 5'd1;

    t_month_view pending_views[$];
    int error_count  = 0;
    int result_count = 0;
    int cycle_count  = 0;
    int burst_left   = 0;
    bit gaps_enabled = 1'b1;
    int hold_seq     = 0;

    int hold_seen   = 0;
    int hold_left   = 0;
    int stall_style = 0;
    int style_left  = 0;
    int stall_tick  = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("calendar_month_navigator_tb: errors");
            $finish;
        end
    end

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // month counted from 0
    function automatic int days_in(int m0, int y);
        case (m0)
            1:          return leap_year(y) ? 29 : 28;
            3, 5, 8, 10: return 30;
            default:    return 31;
        endcase
    endfunction

    // Zeller, 0 Sunday; January and February belong to the year before
    function automatic int weekday_of_1st(int m0, int y);
        int m;
        int k;
        int j;
        int h;
        m = m0 + 1;
        if (m < 3) begin
            m = m + 12;
            y = y - 1;
        end
        k = y % 100;
        j = y / 100;
        h = (1 + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
        return (h + 6) % 7;
    endfunction

    function automatic t_month_view step_calendar(t_nav_cmd c);
        t_month_view v;
        logic        acc;
        acc = 1'b1;
        case (c.op)
            cmn_pkg::OP_PREV: begin
                if (cal_month == 4'd0) begin
                    if (cal_year > cmn_pkg::YEAR_MIN) begin
                        cal_month = 4'd11;
                        cal_year  = cal_year - 14'd1;
                    end
                end else begin
                    cal_month = cal_month - 4'd1;
                end
                cal_pick = 5'd0;
            end
            cmn_pkg::OP_NEXT: begin
                if (cal_month >= 4'd11) begin
                    if (cal_year < cmn_pkg::YEAR_MAX) begin
                        cal_month = 4'd0;
                        cal_year  = cal_year + 14'd1;
                    end
                end else begin
                    cal_month = cal_month + 4'd1;
                end
                cal_pick = 5'd0;
            end
            cmn_pkg::OP_TODAY: begin
                if (c.now_valid && c.now_year >= cmn_pkg::YEAR_MIN &&
                    c.now_year <= cmn_pkg::YEAR_MAX &&
                    c.now_month >= 4'd1 && c.now_month <= 4'd12 && c.now_day >= 5'd1 &&
                    int'(c.now_day) <= days_in(int'(c.now_month) - 1, int'(c.now_year))) begin
                    kept_year   = c.now_year;
                    today_month = c.now_month - 4'd1;
                    today_day   = c.now_day;
                end
                cal_year  = kept_year;
                cal_month = today_month;
                cal_pick  = today_day;
            end
            default: begin
                if (c.day >= 5'd1 && int'(c.day) <= days_in(int'(cal_month), int'(cal_year)))
                begin
                    cal_pick = c.day;
                end else begin
                    acc = 1'b0;
                end
            end
        endcase
        v.year  = cal_year;
        v.month = cal_month;
        v.pick  = cal_pick;
        v.len   = 5'(days_in(int'(cal_month), int'(cal_year)));
        v.dow   = 3'(weekday_of_1st(int'(cal_month), int'(cal_year)));
        v.acc   = acc;
        return v;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        if (error_count <= PRINT_CAP) begin
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     result_count, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        t_month_view want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_views.size() == 0) begin
                report_mismatch("unexpected result, year", int'(o_view_year_out), 0);
            end else begin
                want = pending_views.pop_front();
                if (o_view_year_out != want.year)
                    report_mismatch("view year", int'(o_view_year_out), int'(want.year));
                if (o_view_month_out != want.month)
                    report_mismatch("view month", int'(o_view_month_out), int'(want.month));
                if (o_picked_day != want.pick)
                    report_mismatch("picked day", int'(o_picked_day), int'(want.pick));
                if (o_month_length != want.len)
                    report_mismatch("month length", int'(o_month_length), int'(want.len));
                if (o_first_weekday != want.dow)
                    report_mismatch("first weekday", int'(o_first_weekday), int'(want.dow));
                if (o_accepted != want.acc)
                    report_mismatch("accepted", int'(o_accepted), int'(want.acc));
            end
            result_count++;
        end
    end

    // receiver: changing stall styles, plus a long hold-off on request
    always @(posedge i_clk) begin
        stall_tick++;
        if (hold_seen != hold_seq) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left  = $urandom_range(20, 200);
        end else begin
            style_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            case (stall_style)
                0:       i_stall <= 1'b0;
                1:       i_stall <= ($urandom_range(0, 3) == 0);
                2:       i_stall <= ($urandom_range(0, 3) != 0);
                default: i_stall <= (stall_tick % 3 == 0);
            endcase
        end
    end

    task automatic issue(input t_nav_cmd c);
        i_valid     <= 1'b1;
        i_mode      <= c.op;
        i_day       <= c.day;
        i_now_valid <= c.now_valid;
        i_now_year  <= c.now_year;
        i_now_month <= c.now_month;
        i_now_day   <= c.now_day;
        do @(posedge i_clk); while (o_stall);
        pending_views.push_back(step_calendar(c));
    endtask

    task automatic pause_sender(int n);
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic offer(input t_nav_cmd c);
        if (gaps_enabled && burst_left == 0) begin
            pause_sender($urandom_range(1, 6));
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0) burst_left--;
        issue(c);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_views.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_nav_cmd make_cmd(cmn_pkg::t_op op, int day, bit nv, int ny, int nm,
                                          int nd);
        t_nav_cmd c;
        c.op        = op;
        c.day       = 5'(day);
        c.now_valid = nv;
        c.now_year  = 14'(ny);
        c.now_month = 4'(nm);
        c.now_day   = 5'(nd);
        return c;
    endfunction

    function automatic int rand_year();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(1, 9999);
            1:       return $urandom_range(1, 20);
            2:       return $urandom_range(9980, 9999);
            default: return 100 * $urandom_range(1, 99);
        endcase
    endfunction

    function automatic t_nav_cmd rand_noise();
        return make_cmd(cmn_pkg::t_op'($urandom_range(0, 3)), $urandom_range(0, 31),
                        $urandom_range(0, 1), $urandom_range(0, 16383),
                        $urandom_range(0, 15), $urandom_range(0, 31));
    endfunction

    function automatic t_nav_cmd rand_today(bit good);
        int y;
        int m;
        int d;
        int len;
        bit nv;
        y   = rand_year();
        m   = $urandom_range(1, 12);
        len = days_in(m - 1, y);
        d   = $urandom_range(1, len);
        nv  = 1'b1;
        if (!good) begin
            case ($urandom_range(0, 5))
                0: nv = 1'b0;
                1: y = 0;
                2: y = $urandom_range(10000, 16383);
                3: m = 0;
                4: m = $urandom_range(13, 15);
                default: d = (len < 31) ? $urandom_range(len + 1, 31) : 0;
            endcase
        end
        return make_cmd(cmn_pkg::OP_TODAY, $urandom_range(0, 31), nv, y, m, d);
    endfunction

    function automatic t_nav_cmd rand_browse();
        int d;
        case ($urandom_range(0, 2))
            0: return make_cmd(cmn_pkg::OP_PREV, $urandom_range(0, 31), $urandom_range(0, 1),
                               $urandom_range(0, 16383), $urandom_range(0, 15),
                               $urandom_range(0, 31));
            1: return make_cmd(cmn_pkg::OP_NEXT, $urandom_range(0, 31), $urandom_range(0, 1),
                               $urandom_range(0, 16383), $urandom_range(0, 15),
                               $urandom_range(0, 31));
            default: begin
                if ($urandom_range(0, 9) < 7)
                    d = $urandom_range(1, days_in(int'(cal_month), int'(cal_year)));
                else
                    d = $urandom_range(0, 31);
                return make_cmd(cmn_pkg::OP_SELECT, d, $urandom_range(0, 1),
                                $urandom_range(0, 16383), $urandom_range(0, 15),
                                $urandom_range(0, 31));
            end
        endcase
    endfunction

    task automatic test_year_limits();
        offer(make_cmd(cmn_pkg::OP_TODAY, 0, 1, 1, 1, 1));
        offer(make_cmd(cmn_pkg::OP_PREV, 0, 0, 0, 0, 0));
        offer(make_cmd(cmn_pkg::OP_NEXT, 0, 0, 0, 0, 0));
        offer(make_cmd(cmn_pkg::OP_TODAY, 31, 1, 9999, 12, 31));
        offer(make_cmd(cmn_pkg::OP_NEXT, 31, 1, 16383, 15, 31));
        offer(make_cmd(cmn_pkg::OP_PREV, 0, 0, 0, 0, 0));
    endtask

    task automatic test_select_rules();
        offer(make_cmd(cmn_pkg::OP_TODAY, 0, 1, 2000, 2, 15));
        offer(make_cmd(cmn_pkg::OP_SELECT, 29, 0, 0, 0, 0));
        offer(make_cmd(cmn_pkg::OP_SELECT, 30, 0, 0, 0, 0));
        offer(make_cmd(cmn_pkg::OP_SELECT, 0, 0, 0, 0, 0));
        offer(make_cmd(cmn_pkg::OP_TODAY, 0, 1, 1900, 2, 1));
        offer(make_cmd(cmn_pkg::OP_SELECT, 29, 0, 0, 0, 0));
        offer(make_cmd(cmn_pkg::OP_NEXT, 0, 0, 0, 0, 0));
        offer(make_cmd(cmn_pkg::OP_SELECT, 31, 0, 0, 0, 0));
        offer(make_cmd(cmn_pkg::OP_NEXT, 0, 0, 0, 0, 0));
        offer(make_cmd(cmn_pkg::OP_SELECT, 31, 0, 0, 0, 0));
    endtask

    // bad dates fall back to the last known date
    task automatic test_today_fallback();
        offer(make_cmd(cmn_pkg::OP_TODAY, 0, 0, 2024, 2, 29));
        offer(make_cmd(cmn_pkg::OP_TODAY, 0, 1, 0, 5, 5));
        offer(make_cmd(cmn_pkg::OP_TODAY, 31, 1, 16383, 15, 31));
        offer(make_cmd(cmn_pkg::OP_TODAY, 0, 1, 2024, 0, 5));
        offer(make_cmd(cmn_pkg::OP_TODAY, 0, 1, 2024, 13, 5));
        offer(make_cmd(cmn_pkg::OP_TODAY, 0, 1, 2024, 3, 0));
        offer(make_cmd(cmn_pkg::OP_TODAY, 0, 1, 2023, 4, 31));
        offer(make_cmd(cmn_pkg::OP_TODAY, 0, 1, 2023, 2, 29));
        offer(make_cmd(cmn_pkg::OP_TODAY, 0, 1, 2024, 2, 29));
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        int i;
        gaps_enabled = 1'b0;
        hold_seq++;
        for (i = 0; i < 40; i++) begin
            if (i % 8 == 0) offer(rand_today(1'b1));
            else offer(rand_browse());
        end
        gaps_enabled = 1'b1;
    endtask

    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 10; i++) offer(rand_browse());
        wait_for_results();
        for (i = 0; i < 10; i++) offer(rand_browse());
    endtask

    task automatic test_random_traffic(int total);
        int done;
        int run;
        int kind;
        int i;
        done = 0;
        while (done < total) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                offer(rand_today(1'b1));
                run = $urandom_range(1, 10);
                for (i = 0; i < run; i++) offer(rand_browse());
                done += run + 1;
            end else if (kind < 70) begin
                offer(rand_noise());
                done++;
            end else if (kind < 80) begin
                // walk past the first or last month of the calendar
                if ($urandom_range(0, 1)) begin
                    offer(make_cmd(cmn_pkg::OP_TODAY, 0, 1, $urandom_range(1, 2),
                                   $urandom_range(1, 2), $urandom_range(1, 28)));
                    run = $urandom_range(1, 30);
                    for (i = 0; i < run; i++)
                        offer(($urandom_range(0, 4) == 0) ? rand_browse()
                              : make_cmd(cmn_pkg::OP_PREV, 0, 0, 0, 0, 0));
                end else begin
                    offer(make_cmd(cmn_pkg::OP_TODAY, 0, 1, $urandom_range(9998, 9999),
                                   $urandom_range(11, 12), $urandom_range(1, 30)));
                    run = $urandom_range(1, 30);
                    for (i = 0; i < run; i++)
                        offer(($urandom_range(0, 4) == 0) ? rand_browse()
                              : make_cmd(cmn_pkg::OP_NEXT, 0, 0, 0, 0, 0));
                end
                done += run + 1;
            end else if (kind < 90) begin
                offer(rand_today(1'b0));
                run = $urandom_range(0, 3);
                for (i = 0; i < run; i++) offer(rand_browse());
                done += run + 1;
            end else if (kind < 95) begin
                gaps_enabled = !gaps_enabled;
            end else if (kind < 97) begin
                hold_seq++;
            end else begin
                wait_for_results();
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_year_limits();
        test_select_rules();
        test_today_fallback();
        test_backpressure();
        test_drain_pause();
        test_random_traffic(RANDOM_REQUESTS);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("calendar_month_navigator_tb: clean");
        end else begin
            $display("calendar_month_navigator_tb: errors");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/cmn_pkg.sv
hdl/cmn_front.sv
hdl/cmn_queue.sv
hdl/cmn_exec.sv
hdl/cmn_format.sv
hdl/calendar_month_navigator.sv
hdl/cmn_checker.sv
tb/calendar_month_navigator_tb.sv
